/* sv/prs_pkg.sv */
`timescale 1ns / 1ps

package prs_pkg;

  localparam int unsigned WIDTH_DEF       = 32;
  localparam int unsigned MAX_FACTORS_DEF = 9;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_TD,
    S_TDEND,
    S_G,
    S_EXP,
    S_POW,
    S_MUL,
    S_MULR,
    S_MULB,
    S_CHK,
    S_FIN
  } state_t;

endpackage

/* sv/primitive_root_search_unit.sv */
`timescale 1ns / 1ps

// Returns the least primitive root of the modulus on each in_ beat (1 for a modulus
// of 2, 0 for a modulus below 2 or when no candidate passes, as for some composites).
// One beat is worked at a time; in_ready is low from acceptance until the result
// is stored in the output register. Divides and modular products run on one shared
// bit-serial unit. p-1 is factored by trial division; each candidate then costs one
// divide plus up to 2*WIDTH modular products per prime factor of p-1.
module primitive_root_search_unit #(
  parameter int unsigned WIDTH       = prs_pkg::WIDTH_DEF,
  parameter int unsigned MAX_FACTORS = prs_pkg::MAX_FACTORS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_modulus,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_root
);

  localparam int unsigned CW  = $clog2(WIDTH);
  localparam int unsigned FCW = $clog2(MAX_FACTORS + 1);
  localparam int unsigned FIW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
  localparam logic [CW-1:0]  CNT_LAST = CW'(WIDTH - 1);
  localparam logic [FCW-1:0] FAC_MAX  = FCW'(MAX_FACTORS);
  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);
  localparam logic [WIDTH-1:0] TWO = WIDTH'(2);

  prs_pkg::state_t state_r, state_nxt;

  logic [WIDTH-1:0] p_r, p_nxt, phi_r, phi_nxt, n_r, n_nxt, d_r, d_nxt;
  logic [WIDTH-1:0] g_r, g_nxt, e_r, e_nxt, pr_r, pr_nxt, base_r, base_nxt;
  logic [WIDTH-1:0] res_r, res_nxt;
  logic [FCW-1:0]   fcnt_r, fcnt_nxt, i_r, i_nxt;
  logic             strip_r, strip_nxt, dret_r, dret_nxt, mret_r, mret_nxt;
  logic [WIDTH-1:0] fac_r [MAX_FACTORS];
  logic             fac_we;
  logic [WIDTH-1:0] fac_wd;

  // shared unit: divisor or addend, shifting operand, remainder or accumulator
  logic [WIDTH-1:0] ua_r, ua_nxt, ux_r, ux_nxt, uacc_r, uacc_nxt;
  logic [CW-1:0]    ucnt_r, ucnt_nxt;
  logic             uph_r, uph_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_root_r, out_root_nxt;

  logic [WIDTH:0]   op_x, op_y, op_sum, op_m, op_dif;
  logic             op_ge;
  logic [WIDTH-1:0] op_res;

  always_comb begin
    op_x = {1'b0, uacc_r};
    op_y = '0;
    op_m = {1'b0, p_r};
    if (state_r == prs_pkg::S_DIV) begin
      op_x = {uacc_r, ux_r[WIDTH-1]};
      op_m = {1'b0, ua_r};
    end else if (!uph_r) begin
      op_y = {1'b0, uacc_r};
    end else begin
      op_y = {1'b0, ua_r};
    end
    op_sum = op_x + op_y;
    op_dif = op_sum - op_m;
    op_ge  = (op_sum >= op_m);
    op_res = op_ge ? op_dif[WIDTH-1:0] : op_sum[WIDTH-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    p_nxt = p_r; phi_nxt = phi_r; n_nxt = n_r; d_nxt = d_r;
    g_nxt = g_r; e_nxt = e_r; pr_nxt = pr_r; base_nxt = base_r; res_nxt = res_r;
    fcnt_nxt = fcnt_r; i_nxt = i_r; strip_nxt = strip_r;
    dret_nxt = dret_r; mret_nxt = mret_r;
    ua_nxt = ua_r; ux_nxt = ux_r; uacc_nxt = uacc_r; ucnt_nxt = ucnt_r; uph_nxt = uph_r;
    fac_we = 1'b0;
    fac_wd = n_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_root_nxt  = out_root_r;
    unique case (state_r)
      prs_pkg::S_IDLE: begin
        if (in_valid) begin
          p_nxt    = in_modulus;
          phi_nxt  = in_modulus - ONE;
          n_nxt    = in_modulus - ONE;
          d_nxt    = TWO;
          fcnt_nxt = '0;
          strip_nxt = 1'b0;
          if (in_modulus < TWO) begin
            res_nxt = '0;
            state_nxt = prs_pkg::S_FIN;
          end else if (in_modulus == TWO) begin
            res_nxt = ONE;
            state_nxt = prs_pkg::S_FIN;
          end else begin
            ua_nxt = TWO; ux_nxt = in_modulus - ONE; uacc_nxt = '0; ucnt_nxt = '0;
            dret_nxt = 1'b0;
            state_nxt = prs_pkg::S_DIV;
          end
        end
      end
      prs_pkg::S_DIV: begin
        uacc_nxt = op_res;
        ux_nxt   = {ux_r[WIDTH-2:0], op_ge};
        ucnt_nxt = ucnt_r + 1'b1;
        if (ucnt_r == CNT_LAST) state_nxt = dret_r ? prs_pkg::S_EXP : prs_pkg::S_TD;
      end
      prs_pkg::S_TD: begin
        ua_nxt = d_r; ux_nxt = n_r; uacc_nxt = '0; ucnt_nxt = '0;
        if (strip_r) begin
          if (uacc_r == '0) begin
            n_nxt = ux_r; ux_nxt = ux_r;
          end else begin
            strip_nxt = 1'b0;
            d_nxt = d_r + ONE; ua_nxt = d_r + ONE;
          end
          state_nxt = prs_pkg::S_DIV;
        end else if (d_r > ux_r) begin
          state_nxt = prs_pkg::S_TDEND;
        end else begin
          if (uacc_r == '0) begin
            if (fcnt_r < FAC_MAX) begin
              fac_we = 1'b1; fac_wd = d_r; fcnt_nxt = fcnt_r + 1'b1;
            end
            n_nxt = ux_r; ux_nxt = ux_r; strip_nxt = 1'b1;
          end else begin
            d_nxt = d_r + ONE; ua_nxt = d_r + ONE;
          end
          state_nxt = prs_pkg::S_DIV;
        end
      end
      prs_pkg::S_TDEND: begin
        if (n_r > ONE && fcnt_r < FAC_MAX) begin
          fac_we = 1'b1; fcnt_nxt = fcnt_r + 1'b1;
        end
        g_nxt = TWO; i_nxt = '0;
        state_nxt = prs_pkg::S_G;
      end
      prs_pkg::S_G: begin
        if (g_r >= p_r) begin
          res_nxt = '0; state_nxt = prs_pkg::S_FIN;
        end else if (i_r == fcnt_r) begin
          res_nxt = g_r; state_nxt = prs_pkg::S_FIN;
        end else begin
          ua_nxt = fac_r[i_r[FIW-1:0]]; ux_nxt = phi_r; uacc_nxt = '0; ucnt_nxt = '0;
          dret_nxt = 1'b1;
          state_nxt = prs_pkg::S_DIV;
        end
      end
      prs_pkg::S_EXP: begin
        e_nxt = ux_r; pr_nxt = ONE; base_nxt = g_r;
        state_nxt = prs_pkg::S_POW;
      end
      prs_pkg::S_POW: begin
        uacc_nxt = '0; ucnt_nxt = '0; uph_nxt = 1'b0;
        if (e_r == '0) begin
          state_nxt = prs_pkg::S_CHK;
        end else if (e_r[0]) begin
          ua_nxt = pr_r; ux_nxt = base_r; mret_nxt = 1'b1;
          state_nxt = prs_pkg::S_MUL;
        end else begin
          ua_nxt = base_r; ux_nxt = base_r; mret_nxt = 1'b0;
          state_nxt = prs_pkg::S_MUL;
        end
      end
      prs_pkg::S_MUL: begin
        uph_nxt = !uph_r;
        if (!uph_r) begin
          uacc_nxt = op_res;
        end else begin
          if (ux_r[WIDTH-1]) uacc_nxt = op_res;
          ux_nxt   = {ux_r[WIDTH-2:0], 1'b0};
          ucnt_nxt = ucnt_r + 1'b1;
          if (ucnt_r == CNT_LAST) state_nxt = mret_r ? prs_pkg::S_MULR : prs_pkg::S_MULB;
        end
      end
      prs_pkg::S_MULR: begin
        pr_nxt = uacc_r;
        ua_nxt = base_r; ux_nxt = base_r; uacc_nxt = '0; ucnt_nxt = '0; uph_nxt = 1'b0;
        mret_nxt = 1'b0;
        state_nxt = prs_pkg::S_MUL;
      end
      prs_pkg::S_MULB: begin
        base_nxt = uacc_r;
        e_nxt = e_r >> 1;
        state_nxt = prs_pkg::S_POW;
      end
      prs_pkg::S_CHK: begin
        if (pr_r == ONE) begin
          g_nxt = g_r + ONE; i_nxt = '0;
        end else begin
          i_nxt = i_r + 1'b1;
        end
        state_nxt = prs_pkg::S_G;
      end
      prs_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = res_r;
          state_nxt = prs_pkg::S_IDLE;
        end
      end
      default: state_nxt = prs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == prs_pkg::S_IDLE);
    out_valid = out_valid_r;
    out_root  = out_root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt; phi_r <= phi_nxt; n_r <= n_nxt; d_r <= d_nxt;
    g_r <= g_nxt; e_r <= e_nxt; pr_r <= pr_nxt; base_r <= base_nxt; res_r <= res_nxt;
    fcnt_r <= fcnt_nxt; i_r <= i_nxt; strip_r <= strip_nxt;
    dret_r <= dret_nxt; mret_r <= mret_nxt;
    ua_r <= ua_nxt; ux_r <= ux_nxt; uacc_r <= uacc_nxt; ucnt_r <= ucnt_nxt; uph_r <= uph_nxt;
    out_root_r <= out_root_nxt;
    if (fac_we) fac_r[fcnt_r[FIW-1:0]] <= fac_wd;
  end

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == prs_pkg::S_DIV |-> ua_r != '0)
    else $error("divide by zero in shared unit");
  a_fac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != prs_pkg::S_IDLE |-> fcnt_r <= FAC_MAX)
    else $error("factor count overflow");
  a_mul_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == prs_pkg::S_MUL |-> uacc_r < p_r && ua_r < p_r)
    else $error("modular product operand not reduced");
  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == prs_pkg::S_FIN && state_nxt == prs_pkg::S_IDLE |=> out_valid_r)
    else $error("result lost at output register");
`endif

endmodule
